// ----- sv/dpg_pkg.sv -----
// Shared types and constants of the disk pair geometry unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dpg_pkg;

  typedef logic [1:0] dpg_status_t;

  localparam dpg_status_t ST_OK         = 2'd0;
  localparam dpg_status_t ST_INVALID    = 2'd1;
  localparam dpg_status_t ST_CONCENTRIC = 2'd2;
  localparam dpg_status_t ST_NO_ISECT   = 2'd3;

  localparam logic FN_CONTAIN = 1'b0;
  localparam logic FN_SWEEP   = 1'b1;

  localparam int OFFSET_W = 32;
  localparam int HEIGHT_W = 62;
  localparam int SAT_W    = 41;

  localparam logic [SAT_W-1:0] OFFSET_MAX     = 41'd1099511627;
  localparam logic [SAT_W-1:0] OFFSET_MIN_MAG = 41'd1099511628;

  // decisions made ahead of the divider
  typedef struct packed {
    logic func;
    logic inval;
    logic conc;
    logic contain;
  } dpg_flags_t;

  // per-item tag that rides along the root extraction
  typedef struct packed {
    dpg_status_t status;
    logic        contains;
    logic        neg;
    logic        report;
  } dpg_tag_t;

endpackage

`default_nettype wire

// ----- sv/dpg_if.sv -----
// Valid/ready channel interfaces for queries and results.
// Depends on dpg_pkg for the result field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dpg_query_if #(parameter int W = 30) ();
  logic                valid;
  logic                ready;
  logic                func;
  logic signed [W-1:0] first_x;
  logic signed [W-1:0] first_y;
  logic        [W-1:0] first_rad;
  logic signed [W-1:0] second_x;
  logic signed [W-1:0] second_y;
  logic        [W-1:0] second_rad;
  logic        [W-1:0] tool_rad;

  modport source (output valid, func, first_x, first_y, first_rad, second_x, second_y,
                  second_rad, tool_rad, input ready);
  modport sink (input valid, func, first_x, first_y, first_rad, second_x, second_y,
                second_rad, tool_rad, output ready);
endinterface

interface dpg_result_if import dpg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  dpg_status_t                status;
  logic                       contains;
  logic signed [OFFSET_W-1:0] offset_x;
  logic        [HEIGHT_W-1:0] height_sq;

  modport source (output valid, status, contains, offset_x, height_sq, input ready);
  modport sink (input valid, status, contains, offset_x, height_sq, output ready);
endinterface

`default_nettype wire

// ----- sv/dpg_front.sv -----
// Front pipeline: differences, squares, chord numerator and its exact square.
// Depends on dpg_pkg and dpg_query_if. Seven register stages.
`timescale 1ns / 1ps
`default_nettype none

module dpg_front import dpg_pkg::*; #(
  parameter int W = 30,
  localparam int SW  = 2*W+2,
  localparam int D4W = 2*W+3,
  localparam int NW  = 4*W+6
) (
  input  logic           clk,
  input  logic           rst,
  dpg_query_if.sink      query,
  output logic           valid,
  input  logic           ready,
  output logic [NW-1:0]  num_sq,
  output logic [D4W-1:0] dist4,
  output logic [SW-1:0]  rad2_sq,
  output logic           num_neg,
  output dpg_flags_t     flags
);

  localparam int DW   = 2*W+1;
  localparam int UW   = 2*W+3;
  localparam int NUMW = 2*W+4;
  localparam int HALF = (UW+1)/2;
  localparam int HIW  = UW-HALF;

  logic [7:1] v;
  logic [8:1] go;

  always_comb begin
    go[8] = ready;
    for (int i = 7; i >= 1; i--) go[i] = !v[i] || go[i+1];
  end

  assign query.ready = go[1];
  assign valid       = v[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (go[1]) v[1] <= query.valid;
      for (int i = 2; i <= 7; i++) begin
        if (go[i]) v[i] <= v[i-1];
      end
    end
  end

  // stage 1: center deltas, grown radii
  logic signed [W:0] dx_c, dy_c;
  logic [W-1:0]      adx1, ady1, diff1;
  logic [W:0]        g1_1, g2_1;
  logic              ge1;
  dpg_flags_t        fl1;

  always_comb begin
    dx_c = $signed({query.second_x[W-1], query.second_x})
         - $signed({query.first_x[W-1], query.first_x});
    dy_c = $signed({query.second_y[W-1], query.second_y})
         - $signed({query.first_y[W-1], query.first_y});
  end

  always_ff @(posedge clk) begin
    if (go[1]) begin
      adx1        <= W'(dx_c[W] ? -dx_c : dx_c);
      ady1        <= W'(dy_c[W] ? -dy_c : dy_c);
      g1_1        <= {1'b0, query.first_rad} + {1'b0, query.tool_rad};
      g2_1        <= {1'b0, query.second_rad} + {1'b0, query.tool_rad};
      ge1         <= query.first_rad >= query.second_rad;
      diff1       <= query.first_rad - query.second_rad;
      fl1.func    <= query.func;
      fl1.inval   <= (query.first_rad == '0) || (query.second_rad == '0)
                  || (query.func == FN_SWEEP && query.tool_rad == '0);
      fl1.conc    <= 1'b0;
      fl1.contain <= 1'b0;
    end
  end

  // stage 2: squares
  logic [2*W-1:0] sqx2, sqy2, dsq2;
  logic [SW-1:0]  s1_2, s2_2;
  logic           ge2;
  dpg_flags_t     fl2;

  always_ff @(posedge clk) begin
    if (go[2]) begin
      sqx2 <= adx1 * adx1;
      sqy2 <= ady1 * ady1;
      dsq2 <= diff1 * diff1;
      s1_2 <= g1_1 * g1_1;
      s2_2 <= g2_1 * g2_1;
      ge2  <= ge1;
      fl2  <= fl1;
    end
  end

  // stage 3: squared distance, radius term
  logic [DW-1:0]        d2_3;
  logic signed [SW:0]   s12_3;
  logic [2*W-1:0]       dsq3;
  logic [SW-1:0]        s2_3;
  logic                 ge3;
  dpg_flags_t           fl3;

  always_ff @(posedge clk) begin
    if (go[3]) begin
      d2_3  <= DW'(sqx2) + DW'(sqy2);
      s12_3 <= $signed({1'b0, s1_2}) - $signed({1'b0, s2_2});
      dsq3  <= dsq2;
      s2_3  <= s2_2;
      ge3   <= ge2;
      fl3   <= fl2;
    end
  end

  // stage 4: numerator, containment, concentric check
  logic signed [NUMW-1:0] num4;
  logic [D4W-1:0]         d4_4;
  logic [SW-1:0]          s2_4;
  dpg_flags_t             fl4;

  always_ff @(posedge clk) begin
    if (go[4]) begin
      num4        <= $signed({s12_3[SW], s12_3}) - $signed({3'b000, d2_3});
      d4_4        <= {d2_3, 2'b00};
      s2_4        <= s2_3;
      fl4.func    <= fl3.func;
      fl4.inval   <= fl3.inval;
      fl4.conc    <= d2_3 == '0;
      fl4.contain <= fl3.func == FN_CONTAIN && !fl3.inval && ge3 && (d2_3 <= DW'(dsq3));
    end
  end

  // stage 5: magnitude of numerator
  logic [UW-1:0]  unum5;
  logic           neg5;
  logic [D4W-1:0] d4_5;
  logic [SW-1:0]  s2_5;
  dpg_flags_t     fl5;

  always_ff @(posedge clk) begin
    if (go[5]) begin
      unum5 <= UW'(num4[NUMW-1] ? -num4 : num4);
      neg5  <= num4[NUMW-1];
      d4_5  <= d4_4;
      s2_5  <= s2_4;
      fl5   <= fl4;
    end
  end

  // stage 6: half-word partial products of the square
  logic [2*HIW-1:0]  hh6;
  logic [UW-1:0]     hl6;
  logic [2*HALF-1:0] ll6;
  logic              neg6;
  logic [D4W-1:0]    d4_6;
  logic [SW-1:0]     s2_6;
  dpg_flags_t        fl6;

  always_ff @(posedge clk) begin
    if (go[6]) begin
      hh6  <= unum5[UW-1:HALF] * unum5[UW-1:HALF];
      hl6  <= unum5[UW-1:HALF] * unum5[HALF-1:0];
      ll6  <= unum5[HALF-1:0] * unum5[HALF-1:0];
      neg6 <= neg5;
      d4_6 <= d4_5;
      s2_6 <= s2_5;
      fl6  <= fl5;
    end
  end

  // stage 7: sum of partial products
  always_ff @(posedge clk) begin
    if (go[7]) begin
      num_sq  <= (NW'(hh6) << (2*HALF)) + (NW'(hl6) << (HALF+1)) + NW'(ll6);
      num_neg <= neg6;
      dist4   <= d4_6;
      rad2_sq <= s2_6;
      flags   <= fl6;
    end
  end

endmodule

`default_nettype wire

// ----- sv/dpg_div.sv -----
// Pipelined restoring divider: floor and remainder of num_sq / dist4, one
// quotient bit per stage, then existence test, status and height. Uses dpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpg_div import dpg_pkg::*; #(
  parameter int W = 30,
  localparam int SW  = 2*W+2,
  localparam int D4W = 2*W+3,
  localparam int NW  = 4*W+6
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [NW-1:0]  num_sq,
  input  logic [D4W-1:0] dist4,
  input  logic [SW-1:0]  rad2_sq,
  input  logic           num_neg,
  input  dpg_flags_t     flags,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [SW-1:0]  quot,
  output logic [SW-1:0]  height,
  output dpg_tag_t       tag
);

  localparam int L = SW+2;

  logic [L-1:0] v;
  logic [L:0]   go;

  always_comb begin
    go[L] = out_ready;
    for (int i = L-1; i >= 0; i--) go[i] = !v[i] || go[i+1];
  end

  assign in_ready  = go[0];
  assign out_valid = v[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (go[0]) v[0] <= in_valid;
      for (int i = 1; i < L; i++) begin
        if (go[i]) v[i] <= v[i-1];
      end
    end
  end

  logic [D4W-1:0] rem [0:SW];
  logic [SW-1:0]  qa  [0:SW];
  logic [D4W-1:0] d4a [0:SW];
  logic [SW-1:0]  s2a [0:SW];
  logic           nega[0:SW];
  logic           ovf [0:SW];
  dpg_flags_t     fla [0:SW];

  // quotient must fit SW bits; otherwise no intersection
  always_ff @(posedge clk) begin
    if (go[0]) begin
      rem[0]  <= D4W'(num_sq[NW-1:SW]);
      ovf[0]  <= num_sq[NW-1:SW] >= {1'b0, dist4};
      qa[0]   <= num_sq[SW-1:0];
      d4a[0]  <= dist4;
      s2a[0]  <= rad2_sq;
      nega[0] <= num_neg;
      fla[0]  <= flags;
    end
  end

  for (genvar j = 1; j <= SW; j++) begin : g_step
    logic [D4W:0] trial;
    logic         take;

    assign trial = {rem[j-1], qa[j-1][SW-1]};
    assign take  = trial >= {1'b0, d4a[j-1]};

    always_ff @(posedge clk) begin
      if (go[j]) begin
        rem[j]  <= take ? D4W'(trial - {1'b0, d4a[j-1]}) : trial[D4W-1:0];
        qa[j]   <= {qa[j-1][SW-2:0], take};
        d4a[j]  <= d4a[j-1];
        s2a[j]  <= s2a[j-1];
        nega[j] <= nega[j-1];
        ovf[j]  <= ovf[j-1];
        fla[j]  <= fla[j-1];
      end
    end
  end

  logic          rem_nz, exist_c;
  logic [SW-1:0] hsq_c;
  dpg_status_t   status_c;

  always_comb begin
    rem_nz  = rem[SW] != '0;
    exist_c = !ovf[SW] && ((qa[SW] < s2a[SW]) || (qa[SW] == s2a[SW] && !rem_nz));
    hsq_c   = s2a[SW] - qa[SW] - SW'(rem_nz);
    if (fla[SW].inval) begin
      status_c = ST_INVALID;
    end else if (fla[SW].func == FN_CONTAIN) begin
      status_c = ST_OK;
    end else if (fla[SW].conc) begin
      status_c = ST_CONCENTRIC;
    end else if (!exist_c) begin
      status_c = ST_NO_ISECT;
    end else begin
      status_c = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (go[L-1]) begin
      quot         <= qa[SW];
      height       <= (status_c == ST_OK && fla[SW].func == FN_SWEEP) ? hsq_c : '0;
      tag.status   <= status_c;
      tag.contains <= fla[SW].contain;
      tag.neg      <= nega[SW];
      tag.report   <= status_c == ST_OK && fla[SW].func == FN_SWEEP;
    end
  end

endmodule

`default_nettype wire

// ----- sv/dpg_root.sv -----
// Pipelined integer square root of the quotient, one root bit per stage,
// then offset sign and saturation into the result register. Uses dpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpg_root import dpg_pkg::*; #(
  parameter int W = 30,
  localparam int SW = 2*W+2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [SW-1:0] quot,
  input  logic [SW-1:0] height,
  input  dpg_tag_t      tag,
  dpg_result_if.source  result
);

  localparam int KW = W+1;

  logic [KW:0]   v;
  logic [KW+1:0] go;

  always_comb begin
    go[KW+1] = result.ready;
    for (int i = KW; i >= 0; i--) go[i] = !v[i] || go[i+1];
  end

  assign in_ready     = go[0];
  assign result.valid = v[KW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (go[0]) v[0] <= in_valid;
      for (int i = 1; i <= KW; i++) begin
        if (go[i]) v[i] <= v[i-1];
      end
    end
  end

  logic [SW-1:0] rem [0:KW-1];
  logic [KW-1:0] k   [0:KW-1];
  logic [SW-1:0] hs  [0:KW-1];
  dpg_tag_t      tg  [0:KW-1];

  // rem holds arg - k^2; try setting bit B of k
  for (genvar j = 0; j < KW; j++) begin : g_bit
    localparam int B = KW-1-j;
    logic [SW-1:0] r_in, h_in;
    logic [KW-1:0] k_in;
    dpg_tag_t      t_in;
    logic [SW:0]   trial;
    logic          take;

    if (j == 0) begin : g_src
      assign r_in = quot;
      assign h_in = height;
      assign k_in = '0;
      assign t_in = tag;
    end else begin : g_src
      assign r_in = rem[j-1];
      assign h_in = hs[j-1];
      assign k_in = k[j-1];
      assign t_in = tg[j-1];
    end

    assign trial = ((SW+1)'(k_in) << (B+1)) + ((SW+1)'(1) << (2*B));
    assign take  = trial <= {1'b0, r_in};

    always_ff @(posedge clk) begin
      if (go[j]) begin
        rem[j] <= take ? SW'({1'b0, r_in} - trial) : r_in;
        k[j]   <= take ? (k_in | (KW'(1) << B)) : k_in;
        hs[j]  <= h_in;
        tg[j]  <= t_in;
      end
    end
  end

  logic [SAT_W-1:0]    kk, mag;
  logic [OFFSET_W-1:0] off_c;

  always_comb begin
    kk = SAT_W'(k[KW-1]);
    if (tg[KW-1].neg) begin
      mag = (kk > OFFSET_MIN_MAG) ? OFFSET_MIN_MAG : kk;
    end else begin
      mag = (kk > OFFSET_MAX) ? OFFSET_MAX : kk;
    end
    if (!tg[KW-1].report) begin
      off_c = '0;
    end else if (tg[KW-1].neg) begin
      off_c = OFFSET_W'(SAT_W'(0) - mag);
    end else begin
      off_c = OFFSET_W'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (go[KW]) begin
      result.status    <= tg[KW-1].status;
      result.contains  <= tg[KW-1].contains;
      result.offset_x  <= off_c;
      result.height_sq <= HEIGHT_W'(hs[KW-1]);
    end
  end

endmodule

`default_nettype wire

// ----- sv/disk_pair_geometry_unit.sv -----
// Disk pair geometry unit, top level.
// Channels: query (sink) carries func, two disks and the tool radius;
// result (source) carries status, contains, offset_x and height_sq.
// Both are valid/ready; an item moves on an edge with valid and ready high.
// func 0 tests whether the first disk contains the second. func 1 grows both
// disks by the tool radius and returns the chord offset along the center line
// and the squared half-chord height, or a status for a zero radius,
// concentric centers or no real intersection.
// Pipeline stages: 7 front stages, a divider of 2*COORD_WIDTH+4 stages (an input
// stage, then one quotient bit per stage, then the output stage) and a root
// extractor of COORD_WIDTH+2 stages (one root bit each, plus the output stage).
// Throughput: one item per cycle while result.ready stays high.
// Every stage has its own valid bit; a stage takes a new item when it is empty
// or its successor moves, so a stalled receiver fills the bubbles first and
// then holds query.ready low. Nothing is dropped or repeated.
// Reset (rst, synchronous) clears all valid bits; no item is in flight after.
// Depends on dpg_pkg, dpg_if, dpg_front, dpg_div and dpg_root.
`timescale 1ns / 1ps
`default_nettype none

module disk_pair_geometry_unit import dpg_pkg::*; #(
  parameter int COORD_WIDTH = 30
) (
  input logic          clk,
  input logic          rst,
  dpg_query_if.sink    query,
  dpg_result_if.source result
);

  localparam int SW  = 2*COORD_WIDTH+2;
  localparam int D4W = 2*COORD_WIDTH+3;
  localparam int NW  = 4*COORD_WIDTH+6;

  logic           f_valid, f_ready;
  logic [NW-1:0]  num_sq;
  logic [D4W-1:0] dist4;
  logic [SW-1:0]  rad2_sq;
  logic           num_neg;
  dpg_flags_t     flags;

  logic           d_valid, d_ready;
  logic [SW-1:0]  quot, height;
  dpg_tag_t       tag;

  dpg_front #(.W(COORD_WIDTH)) u_front (
    .clk     (clk),
    .rst     (rst),
    .query   (query),
    .valid   (f_valid),
    .ready   (f_ready),
    .num_sq  (num_sq),
    .dist4   (dist4),
    .rad2_sq (rad2_sq),
    .num_neg (num_neg),
    .flags   (flags)
  );

  dpg_div #(.W(COORD_WIDTH)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .num_sq    (num_sq),
    .dist4     (dist4),
    .rad2_sq   (rad2_sq),
    .num_neg   (num_neg),
    .flags     (flags),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .quot      (quot),
    .height    (height),
    .tag       (tag)
  );

  dpg_root #(.W(COORD_WIDTH)) u_root (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_valid),
    .in_ready (d_ready),
    .quot     (quot),
    .height   (height),
    .tag      (tag),
    .result   (result)
  );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for the disk pair geometry unit: directed table plus random queries.
// Results are checked in order against an exact 128-bit integer predictor.
// Depends on dpg_pkg, dpg_if and disk_pair_geometry_unit.
`timescale 1ns / 1ps

module tb_top;
  import dpg_pkg::*;

  localparam int CW = 30;
  localparam int N_RAND = 1000;
  localparam int LATENCY = 3 * CW + 13;

  typedef struct {
    logic                 func;
    logic signed [CW-1:0] ax, ay;
    logic        [CW-1:0] r1;
    logic signed [CW-1:0] bx, by;
    logic        [CW-1:0] r2, t;
  } query_t;

  typedef struct packed {
    dpg_status_t                status;
    logic                       contains;
    logic signed [OFFSET_W-1:0] offset_x;
    logic        [HEIGHT_W-1:0] height_sq;
  } answer_t;

  // directed row: query plus optional typed-in answer
  typedef struct {
    query_t  q;
    bit      fixed;
    answer_t a;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  bit   failed = 0;

  dpg_query_if #(.W(CW)) query ();
  dpg_result_if result ();

  disk_pair_geometry_unit #(.COORD_WIDTH(CW)) i_dut (
    .clk(clk), .rst(rst), .query(query), .result(result)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  answer_t pending[$];
  row_t    table_rows[$];
  bit      stim_done = 0;
  bit      hold_long = 0;

  // exact disk geometry, 128-bit arithmetic
  function automatic answer_t geometry(query_t q);
    answer_t a;
    logic signed [127:0] dx, dy, d2, g1, g2, s1, s2, num, unum, d4;
    logic [127:0] nsq, bound, k, c, hsq, quo;
    logic [127:0] diff;
    a = '{ST_OK, 1'b0, '0, '0};
    dx = 128'(signed'(q.bx)) - 128'(signed'(q.ax));
    dy = 128'(signed'(q.by)) - 128'(signed'(q.ay));
    d2 = dx * dx + dy * dy;
    if (q.func == FN_CONTAIN) begin
      if (q.r1 == 0 || q.r2 == 0) a.status = ST_INVALID;
      else if (q.r1 >= q.r2) begin
        diff = 128'(q.r1) - 128'(q.r2);
        a.contains = (d2 <= diff * diff);
      end
      return a;
    end
    if (q.t == 0 || q.r1 == 0 || q.r2 == 0) begin
      a.status = ST_INVALID;
      return a;
    end
    if (d2 == 0) begin
      a.status = ST_CONCENTRIC;
      return a;
    end
    g1 = 128'(q.r1) + 128'(q.t);
    g2 = 128'(q.r2) + 128'(q.t);
    s1 = g1 * g1;
    s2 = g2 * g2;
    num = s1 - s2 - d2;
    unum = num < 0 ? -num : num;
    d4 = d2 * 4;
    nsq = unum * unum;
    bound = d4 * s2;
    if (nsq > bound) begin
      a.status = ST_NO_ISECT;
      return a;
    end
    quo = (nsq + d4 - 1) / d4;
    hsq = s2 - quo;
    k = 0;
    for (int b = 30; b >= 0; b--) begin
      c = k | (128'd1 << b);
      if (c * c * d4 <= nsq) k = c;
    end
    if (num >= 0) begin
      if (k > OFFSET_MAX) k = OFFSET_MAX;
      a.offset_x = k[31:0];
    end else begin
      if (k > OFFSET_MIN_MAG) k = OFFSET_MIN_MAG;
      a.offset_x = -k[31:0];
    end
    a.height_sq = hsq[HEIGHT_W-1:0];
    return a;
  endfunction

  function automatic query_t mk(logic f, int ax, int ay, int r1, int bx, int by,
                                int r2, int t);
    query_t q;
    q.func = f; q.ax = CW'(ax); q.ay = CW'(ay); q.r1 = CW'(r1);
    q.bx = CW'(bx); q.by = CW'(by); q.r2 = CW'(r2); q.t = CW'(t);
    return q;
  endfunction

  function automatic logic [CW-1:0] rnd_field();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return {1'b0, {(CW-1){1'b1}}};
      2: return {1'b1, {(CW-1){1'b0}}};
      3: return {CW{1'b1}};
      4: return CW'($urandom_range(0, 32'h3_0000));
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic query_t rnd_query();
    query_t q;
    int span;
    q.func = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) < 7) begin
      // mostly well-formed: nearby disks of comparable size
      span = 1 << $urandom_range(8, 27);
      q.ax = CW'($signed(CW'($urandom_range(0, span))) - (span / 2));
      q.ay = CW'($signed(CW'($urandom_range(0, span))) - (span / 2));
      q.bx = CW'(q.ax + $signed(CW'($urandom_range(0, span))) - (span / 2));
      q.by = CW'(q.ay + $signed(CW'($urandom_range(0, span))) - (span / 2));
      q.r1 = CW'($urandom_range(1, span));
      q.r2 = CW'($urandom_range(1, span));
      q.t = CW'($urandom_range(1, span / 4 + 1));
    end else begin
      q.ax = rnd_field(); q.ay = rnd_field(); q.r1 = rnd_field();
      q.bx = rnd_field(); q.by = rnd_field(); q.r2 = rnd_field();
      q.t = rnd_field();
    end
    return q;
  endfunction

  task automatic send(query_t q);
    int gap;
    gap = hold_long ? 0 : $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      query.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    query.valid      <= 1'b1;
    query.func       <= q.func;
    query.first_x    <= q.ax;
    query.first_y    <= q.ay;
    query.first_rad  <= q.r1;
    query.second_x   <= q.bx;
    query.second_y   <= q.by;
    query.second_rad <= q.r2;
    query.tool_rad   <= q.t;
    do @(posedge clk); while (!query.ready);
  endtask

  task automatic add_row(query_t q, bit fixed = 0, answer_t a = '{ST_OK, 0, 0, 0});
    row_t r;
    r.q = q; r.fixed = fixed; r.a = a;
    table_rows.push_back(r);
  endtask

  localparam int PMAX = 536870911;
  localparam int PMIN = -536870912;
  localparam int RMAX = 1073741823;

  initial begin
    query_t q;
    query.valid = 0; query.func = 0;
    query.first_x = 0; query.first_y = 0; query.first_rad = 0;
    query.second_x = 0; query.second_y = 0; query.second_rad = 0; query.tool_rad = 0;
    // invalid radius cases
    add_row(mk(FN_CONTAIN, 0, 0, 0, 0, 0, 5, 0), 1, '{ST_INVALID, 0, 0, 0});
    add_row(mk(FN_CONTAIN, 0, 0, 5, 0, 0, 0, 0), 1, '{ST_INVALID, 0, 0, 0});
    add_row(mk(FN_SWEEP, 0, 0, 5, 9, 0, 5, 0), 1, '{ST_INVALID, 0, 0, 0});
    add_row(mk(FN_SWEEP, 0, 0, 0, 9, 0, 5, 1), 1, '{ST_INVALID, 0, 0, 0});
    add_row(mk(FN_SWEEP, 0, 0, 5, 9, 0, 0, 1), 1, '{ST_INVALID, 0, 0, 0});
    // concentric
    add_row(mk(FN_SWEEP, 7, -7, 5, 7, -7, 3, 1), 1, '{ST_CONCENTRIC, 0, 0, 0});
    add_row(mk(FN_SWEEP, PMIN, PMAX, RMAX, PMIN, PMAX, RMAX, RMAX), 1,
            '{ST_CONCENTRIC, 0, 0, 0});
    // containment: equal disks, touching inside, just outside, smaller first, extremes
    add_row(mk(FN_CONTAIN, 3, 3, 10, 3, 3, 10, 0), 1, '{ST_OK, 1, 0, 0});
    add_row(mk(FN_CONTAIN, 0, 0, 10, 4, 0, 6, 0), 1, '{ST_OK, 1, 0, 0});
    add_row(mk(FN_CONTAIN, 0, 0, 10, 5, 0, 6, 0), 1, '{ST_OK, 0, 0, 0});
    add_row(mk(FN_CONTAIN, 0, 0, 5, 0, 0, 6, 0), 1, '{ST_OK, 0, 0, 0});
    add_row(mk(FN_CONTAIN, PMIN, PMIN, RMAX, PMAX, PMAX, 1, RMAX));
    add_row(mk(FN_CONTAIN, PMAX, PMIN, RMAX, PMIN, PMAX, RMAX, 0));
    // far apart: no intersection
    add_row(mk(FN_SWEEP, PMIN, PMIN, 1, PMAX, PMAX, 1, 1), 1, '{ST_NO_ISECT, 0, 0, 0});
    // sweeps: extremes and ordinary cases
    add_row(mk(FN_SWEEP, PMIN, PMIN, RMAX, PMAX, PMAX, RMAX, RMAX));
    add_row(mk(FN_SWEEP, PMAX, PMAX, RMAX, PMIN, PMIN, 1, RMAX));
    add_row(mk(FN_SWEEP, 0, 0, 1, 1, 0, RMAX, RMAX));
    add_row(mk(FN_SWEEP, 0, 0, 1, 1, 1, 1, 1));
    add_row(mk(FN_SWEEP, 0, 0, 65536 * 3, 65536 * 4, 0, 65536 * 2, 65536));
    add_row(mk(FN_SWEEP, 0, 0, 65536, 65536 * 4, 0, 65536 * 3, 65536));
    add_row(mk(FN_SWEEP, -100, 50, 1000, 300, -200, 700, 10));
    add_row(mk(FN_SWEEP, 0, 0, 2, 1, 0, 100, 1));
    add_row(mk(FN_SWEEP, 0, 0, 100, 1, 0, 2, 1));
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (table_rows[i]) begin
      answer_t a;
      a = geometry(table_rows[i].q);
      if (table_rows[i].fixed && a != table_rows[i].a) begin
        $error("table row %0d: predictor disagrees with typed answer", i);
        failed = 1;
      end
      pending.push_back(table_rows[i].fixed ? table_rows[i].a : a);
      send(table_rows[i].q);
    end
    for (int n = 0; n < N_RAND; n++) begin
      if (n == 300) begin
        // pause until the pipe drains
        query.valid <= 1'b0;
        wait (pending.size() == 0);
        @(posedge clk);
      end
      if (n == 500) hold_long = 1;
      if (n == 900) hold_long = 0;
      q = rnd_query();
      pending.push_back(geometry(q));
      send(q);
    end
    query.valid <= 1'b0;
    stim_done = 1;
  end

  // receiver: random stalls, one long hold-off
  initial begin
    int gap;
    result.ready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        result.ready <= 1'b0;
        repeat (3 * LATENCY) @(posedge clk);
        hold_long = 0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
          result.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
      // hold ready high for the next item
    end
  end

  always @(posedge clk) begin
    answer_t e;
    if (!rst && result.valid && result.ready) begin
      if (pending.size() == 0) begin
        $error("result item with no expectation");
        failed = 1;
      end else begin
        e = pending.pop_front();
        if (result.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, result.status);
          failed = 1;
        end
        if (result.contains !== e.contains) begin
          $error("contains: expected %0d, got %0d", e.contains, result.contains);
          failed = 1;
        end
        if (result.offset_x !== e.offset_x) begin
          $error("offset_x: expected %0d, got %0d", e.offset_x, result.offset_x);
          failed = 1;
        end
        if (result.height_sq !== e.height_sq) begin
          $error("height_sq: expected %0d, got %0d", e.height_sq, result.height_sq);
          failed = 1;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (pending.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (!failed) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #4ms;
    $display("tb_top: FAIL");
    $finish;
  end
endmodule

// ----- files.f -----
sv/dpg_pkg.sv
sv/dpg_if.sv
sv/dpg_front.sv
sv/dpg_div.sv
sv/dpg_root.sv
sv/disk_pair_geometry_unit.sv
tb/tb_top.sv
